@@ hdl/led_matrix_bit_plane_scanner_defines.svh @@
// Assertion macros for the LED matrix scanner.
// Each property is checked on the rising clock edge and is disabled while reset is active.
`ifndef LED_MATRIX_BIT_PLANE_SCANNER_DEFINES_SVH
`define LED_MATRIX_BIT_PLANE_SCANNER_DEFINES_SVH

`ifndef ASSERT_OFF
`define LMBPS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LMBPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LMBPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LMBPS_ASSERT(label, clk, rst_n, prop, msg)
`define LMBPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LMBPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hdl/lmbps_pkg.sv @@
`timescale 1ns / 1ps

package lmbps_pkg;

	localparam int ROWS_DEF        = 4;
	localparam int COLUMNS_DEF     = 6;
	localparam int PLANE_COUNT_DEF = 4;
	localparam int CHANNELS        = 3;

	localparam int OPCODE_W  = 1;
	localparam int ROW_W     = 2;
	localparam int COL_W     = 3;
	localparam int COLOUR_W  = 2;
	localparam int VALUE_W   = 4;
	localparam int COUNT_W   = 8;
	localparam int MASK_W    = 8;
	localparam int PLANE_W   = 3;
	localparam int MISSED_W  = 16;
	localparam int PIX_SEL_W = $clog2(VALUE_W);

	localparam logic [MISSED_W-1:0] MISSED_MAX = '1;
	localparam logic [MASK_W-1:0]   ANODES_OFF = '1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_WRITE = 1'b0,
		OP_TICK  = 1'b1
	} opcode_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_ctl_t;

endpackage

@@ hdl/lmbps_in_if.sv @@
`timescale 1ns / 1ps

interface lmbps_in_if import lmbps_pkg::*;;
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [ROW_W-1:0]    pixel_row;
	logic [COL_W-1:0]    pixel_column;
	logic [COLOUR_W-1:0] pixel_colour;
	logic [VALUE_W-1:0]  pixel_value;
	logic [COUNT_W-1:0]  tick_count;

	modport source (
		output valid, opcode, pixel_row, pixel_column, pixel_colour, pixel_value, tick_count,
		input  ready
	);
	modport sink (
		input  valid, opcode, pixel_row, pixel_column, pixel_colour, pixel_value, tick_count,
		output ready
	);
endinterface

@@ hdl/lmbps_out_if.sv @@
`timescale 1ns / 1ps

interface lmbps_out_if import lmbps_pkg::*;;
	logic                valid;
	logic                ready;
	logic                serial_bit;
	logic                latch_now;
	logic [MASK_W-1:0]   anode_mask;
	logic [COL_W-1:0]    scan_column;
	logic [PLANE_W-1:0]  scan_plane;
	logic [MISSED_W-1:0] missed_total;

	modport source (
		output valid, serial_bit, latch_now, anode_mask, scan_column, scan_plane, missed_total,
		input  ready
	);
	modport sink (
		input  valid, serial_bit, latch_now, anode_mask, scan_column, scan_plane, missed_total,
		output ready
	);
endinterface

@@ hdl/lmbps_store.sv @@
`timescale 1ns / 1ps

module lmbps_store import lmbps_pkg::*; #(
	parameter int DEPTH = ROWS_DEF * COLUMNS_DEF * CHANNELS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  store_ctl_t         ctl,
	input  logic [AW-1:0]      wr_addr,
	input  logic [VALUE_W-1:0] wr_data,
	input  logic [AW-1:0]      rd_addr,
	output logic [VALUE_W-1:0] rd_data
);

	logic [VALUE_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]   valid_q;
	logic [VALUE_W-1:0] rd_data_q;
	logic               rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// An entry never written since reset reads as dark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

@@ hdl/lmbps_scan.sv @@
`timescale 1ns / 1ps

module lmbps_scan import lmbps_pkg::*; #(
	parameter int ROWS        = ROWS_DEF,
	parameter int COLUMNS     = COLUMNS_DEF,
	parameter int PLANE_COUNT = PLANE_COUNT_DEF,
	localparam int AW = $clog2(ROWS * COLUMNS * CHANNELS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_go,
	input  logic [MISSED_W-1:0] missed,
	output logic                idle,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr,
	input  logic [VALUE_W-1:0]  rd_data,
	lmbps_out_if.source         scan_out
);

	localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW      = $clog2(COLUMNS);
	localparam int PW      = $clog2(PLANE_COUNT + 1);
	localparam int CHW     = $clog2(CHANNELS);
	localparam int LAST_CH = CHANNELS - 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PRIME,
		S_SEND
	} state_t;

	state_t              state_q;
	logic [RW-1:0]       row_q;
	logic [CHW-1:0]      ch_q;
	logic                last_q;
	logic [CW-1:0]       col_q;
	logic [PW-1:0]       plane_q;
	logic                out_valid_q;
	logic                bit_q;
	logic                latch_q;
	logic [MASK_W-1:0]   mask_q;
	logic [COL_W-1:0]    out_col_q;
	logic [PLANE_W-1:0]  out_plane_q;
	logic [MISSED_W-1:0] out_missed_q;

	logic                    out_free;
	logic                    emit;
	logic                    last_ptr;
	logic [RW-1:0]           row_nx;
	logic [CHW-1:0]          ch_nx;
	logic [CW:0]             anode_pos;
	logic [MASK_W-1:0]       anode;
	logic [PIX_SEL_W+PW-1:0] plane_x;
	logic [COL_W+CW-1:0]     col_x;
	logic [PLANE_W+PW-1:0]   plane_out_x;
	logic                    frame_bit;

	assign out_free = !out_valid_q || scan_out.ready;
	assign emit     = (state_q == S_SEND) && out_free;
	assign idle     = (state_q == S_IDLE);
	assign rd_en    = (state_q == S_PRIME) || ((state_q == S_SEND) && out_free && !last_q);

	// The read pointer walks the current column from the last row down to row 0, channels in index order per row.
	assign rd_addr  = AW'((int'(row_q) * COLUMNS + int'(col_q)) * CHANNELS + int'(ch_q));
	assign last_ptr = (row_q == '0) && (ch_q == CHW'(LAST_CH));

	always_comb begin
		if (ch_q == CHW'(LAST_CH)) begin
			ch_nx  = '0;
			row_nx = row_q - RW'(1);
		end else begin
			ch_nx  = ch_q + CHW'(1);
			row_nx = row_q;
		end
	end

	// The last column drives the anode one place above its own index.
	always_comb begin
		if (col_q == CW'(COLUMNS - 1)) begin
			anode_pos = (CW + 1)'(COLUMNS);
		end else begin
			anode_pos = {1'b0, col_q};
		end
		if (int'(anode_pos) >= MASK_W) begin
			anode = ANODES_OFF;
		end else begin
			anode = ~(MASK_W'(1) << anode_pos);
		end
	end

	assign plane_x     = {PIX_SEL_W'(0), plane_q};
	assign col_x       = {COL_W'(0), col_q};
	assign plane_out_x = {PLANE_W'(0), plane_q};
	assign frame_bit   = (int'(plane_q) < VALUE_W) ? rd_data[plane_x[PIX_SEL_W-1:0]] : 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			row_q        <= '0;
			ch_q         <= '0;
			last_q       <= 1'b0;
			col_q        <= '0;
			plane_q      <= '0;
			out_valid_q  <= 1'b0;
			bit_q        <= 1'b0;
			latch_q      <= 1'b0;
			mask_q       <= ANODES_OFF;
			out_col_q    <= '0;
			out_plane_q  <= '0;
			out_missed_q <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (scan_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (tick_go) begin
						row_q   <= RW'(ROWS - 1);
						ch_q    <= '0;
						state_q <= S_PRIME;
					end
				end
				S_PRIME: begin
					row_q   <= row_nx;
					ch_q    <= ch_nx;
					last_q  <= last_ptr;
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (out_free) begin
						bit_q        <= frame_bit;
						latch_q      <= last_q;
						mask_q       <= last_q ? anode : ANODES_OFF;
						out_col_q    <= col_x[COL_W-1:0];
						out_plane_q  <= plane_out_x[PLANE_W-1:0];
						out_missed_q <= missed;
						if (last_q) begin
							state_q <= S_IDLE;
							if (col_q == CW'(COLUMNS - 1)) begin
								col_q   <= '0;
								plane_q <= (plane_q == PW'(PLANE_COUNT)) ? '0 : plane_q + PW'(1);
							end else begin
								col_q <= col_q + CW'(1);
							end
						end else begin
							row_q  <= row_nx;
							ch_q   <= ch_nx;
							last_q <= last_ptr;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign scan_out.valid        = out_valid_q;
	assign scan_out.serial_bit   = bit_q;
	assign scan_out.latch_now    = latch_q;
	assign scan_out.anode_mask   = mask_q;
	assign scan_out.scan_column  = out_col_q;
	assign scan_out.scan_plane   = out_plane_q;
	assign scan_out.missed_total = out_missed_q;

endmodule

@@ hdl/led_matrix_bit_plane_scanner.sv @@
`timescale 1ns / 1ps
// Channel    Role    Transfer carries
// pix_in     sink    opcode, pixel_row, pixel_column, pixel_colour, pixel_value, tick_count
// scan_out   source  serial_bit, latch_now, anode_mask, scan_column, scan_plane, missed_total
//
// A tick is accepted, then the pixel memory read is primed, then one frame bit per cycle follows
// for 3*ROWS bits while scan_out does not stall, paced by the single read port of the pixel
// memory. A stall on scan_out holds the read pointer.
// Reset is asynchronous; the pixel valid bits clear at once, so no clearing pass is needed.
`include "led_matrix_bit_plane_scanner_defines.svh"

module led_matrix_bit_plane_scanner import lmbps_pkg::*; #(
	parameter int ROWS        = ROWS_DEF,
	parameter int COLUMNS     = COLUMNS_DEF,
	parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lmbps_in_if.sink    pix_in,
	lmbps_out_if.source scan_out
);

	localparam int DEPTH = ROWS * COLUMNS * CHANNELS;
	localparam int AW    = $clog2(DEPTH);

	logic                in_xfer;
	logic                tick_go;
	logic                wr_hit;
	logic                idle;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic [VALUE_W-1:0]  rd_data;
	logic [MISSED_W-1:0] missed_q;
	logic [MISSED_W:0]   missed_sum;
	store_ctl_t          store_ctl;

	assign pix_in.ready = idle;
	assign in_xfer      = pix_in.valid && pix_in.ready;
	assign tick_go      = in_xfer && (pix_in.opcode == OP_TICK);

	// Writes outside the matrix or to the unused colour code are dropped.
	assign wr_hit = in_xfer && (pix_in.opcode == OP_WRITE)
		&& (int'(pix_in.pixel_row) < ROWS)
		&& (int'(pix_in.pixel_column) < COLUMNS)
		&& (int'(pix_in.pixel_colour) < CHANNELS);
	assign wr_addr = AW'((int'(pix_in.pixel_row) * COLUMNS + int'(pix_in.pixel_column))
		* CHANNELS + int'(pix_in.pixel_colour));

	assign store_ctl = '{wr_en: wr_hit, rd_en: rd_en};

	assign missed_sum = {1'b0, missed_q} + (MISSED_W + 1)'(pix_in.tick_count - COUNT_W'(1));

	// A count of one is the normal case and a count of zero adds nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			missed_q <= '0;
		end else if (tick_go && (pix_in.tick_count > COUNT_W'(1))) begin
			missed_q <= missed_sum[MISSED_W] ? MISSED_MAX : missed_sum[MISSED_W-1:0];
		end
	end

	lmbps_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (store_ctl),
		.wr_addr (wr_addr),
		.wr_data (pix_in.pixel_value),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	lmbps_scan #(
		.ROWS        (ROWS),
		.COLUMNS     (COLUMNS),
		.PLANE_COUNT (PLANE_COUNT)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick_go  (tick_go),
		.missed   (missed_q),
		.idle     (idle),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.scan_out (scan_out)
	);

	`LMBPS_ASSERT_IMP(a_mask_single, clk, arst_n, scan_out.valid && scan_out.latch_now, $countones(~scan_out.anode_mask) <= 1, "latched anode mask selects more than one anode")
	`LMBPS_ASSERT_IMP(a_mask_off, clk, arst_n, scan_out.valid && !scan_out.latch_now, scan_out.anode_mask == ANODES_OFF, "anode mask active outside the latch bit")
	`LMBPS_ASSERT_IMP(a_busy_mid_frame, clk, arst_n, scan_out.valid && !scan_out.latch_now, !pix_in.ready, "input accepted in the middle of a frame")
	`LMBPS_ASSERT_NXT(a_missed_mono, clk, arst_n, 1'b1, missed_q >= $past(missed_q), "missed tick total decreased")

endmodule
